/* rtl/evd_pkg.sv */
package evd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LEFT_W  = 3;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_VALUES = 3'd0;

    localparam logic [COUNT_W-1:0] MAX_VALUES_RST = 16'd128;

    // escape codes
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'd255;
    localparam logic [BYTE_W-1:0] ESC_ZERO  = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_SHORT = 8'd254;
    localparam logic [BYTE_W-1:0] ESC_LONG  = 8'd253;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;

    localparam logic [LEFT_W-1:0] SHORT_BYTES = 3'd2;
    localparam logic [LEFT_W-1:0] LONG_BYTES  = 3'd4;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_end;
        logic [COUNT_W-1:0] value_count;
        logic               bad_escape;
    } t_result;

endpackage

/* rtl/evd_in_if.sv */
interface evd_in_if;
    import evd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

/* rtl/evd_out_if.sv */
interface evd_out_if;
    import evd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               is_end;
    logic [COUNT_W-1:0] value_count;
    logic               bad_escape;

    modport source (output valid, output value, output is_end, output value_count,
                    output bad_escape, input ready);
    modport sink (input valid, input value, input is_end, input value_count,
                  input bad_escape, output ready);
endinterface

/* rtl/evd_cfg.sv */
module evd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [evd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [evd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [evd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [evd_pkg::COUNT_W-1:0]        o_max_values
);
    import evd_pkg::*;

    logic [COUNT_W-1:0] r_max_values;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_VALUES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_values <= MAX_VALUES_RST;
        end else if (wr_en) begin
            r_max_values <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MAX_VALUES) begin
            prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_max_values};
        end
    end

    assign o_max_values = r_max_values;

endmodule

/* rtl/evd_core.sv */
module evd_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [evd_pkg::BYTE_W-1:0]   i_code_byte,
    input  logic [evd_pkg::COUNT_W-1:0]  i_max_values,
    output logic                         o_has_result,
    output evd_pkg::t_result             o_result
);
    import evd_pkg::*;

    typedef enum logic [2:0] {
        PH_BOUNDARY  = 3'd0,
        PH_TOP_ESC   = 3'd1,
        PH_MULTI     = 3'd2,
        PH_MULTI_ESC = 3'd3,
        PH_DISCARD   = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_err, n_err;

    logic               emit, fin, shift;
    logic [VALUE_W-1:0] emit_val;
    logic [BYTE_W-1:0]  shift_b;
    logic [VALUE_W-1:0] sh_acc;
    logic [LEFT_W-1:0]  sh_left;
    t_result            res;

    assign sh_acc  = {r_acc[VALUE_W-BYTE_W-1:0], shift_b};
    assign sh_left = r_left - 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_left   = r_left;
        n_count  = r_count;
        n_err    = r_err;
        emit     = 1'b0;
        emit_val = '0;
        fin      = 1'b0;
        shift    = 1'b0;
        shift_b  = '0;
        res      = '0;

        case (r_phase)
            PH_BOUNDARY: begin
                if (i_code_byte == TERM_BYTE) begin
                    fin = 1'b1;
                end else if (r_count >= i_max_values) begin
                    n_phase = PH_DISCARD;
                end else if (i_code_byte == ESC_BYTE) begin
                    n_phase = PH_TOP_ESC;
                end else begin
                    emit     = 1'b1;
                    emit_val = {{(VALUE_W-BYTE_W){1'b0}}, i_code_byte};
                end
            end
            PH_TOP_ESC: begin
                if (i_code_byte == ESC_BYTE) begin
                    emit     = 1'b1;
                    emit_val = {{(VALUE_W-BYTE_W){1'b0}}, ESC_BYTE};
                end else if (i_code_byte == ESC_ZERO) begin
                    emit = 1'b1;
                end else if (i_code_byte inside {ESC_SHORT, ESC_LONG}) begin
                    n_acc   = '0;
                    n_left  = (i_code_byte == ESC_SHORT) ? SHORT_BYTES : LONG_BYTES;
                    n_phase = PH_MULTI;
                end else begin
                    n_err = 1'b1;
                    emit  = 1'b1;
                end
            end
            PH_MULTI: begin
                if (i_code_byte == ESC_BYTE) begin
                    n_phase = PH_MULTI_ESC;
                end else begin
                    shift   = 1'b1;
                    shift_b = i_code_byte;
                end
            end
            PH_MULTI_ESC: begin
                shift = 1'b1;
                if (i_code_byte == ESC_BYTE) begin
                    shift_b = ESC_BYTE;
                end else if (i_code_byte != ESC_ZERO) begin
                    // unknown code inside an integer contributes a zero byte
                    n_err = 1'b1;
                end
            end
            PH_DISCARD: begin
                if (i_code_byte == TERM_BYTE) begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_phase = PH_BOUNDARY;
            end
        endcase

        if (shift) begin
            if (sh_left == '0) begin
                emit     = 1'b1;
                emit_val = sh_acc;
            end else begin
                n_acc   = sh_acc;
                n_left  = sh_left;
                n_phase = PH_MULTI;
            end
        end

        if (emit) begin
            res.value       = emit_val - 1'b1;
            res.bad_escape  = n_err;
            n_count         = r_count + 1'b1;
            n_phase         = PH_BOUNDARY;
            n_acc           = '0;
            n_left          = '0;
        end

        if (fin) begin
            // flag reported before the message state clears
            res.is_end      = 1'b1;
            res.value_count = r_count;
            res.bad_escape  = n_err;
            n_phase         = PH_BOUNDARY;
            n_acc           = '0;
            n_left          = '0;
            n_count         = '0;
            n_err           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BOUNDARY;
            r_acc   <= '0;
            r_left  <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_has_result = i_accept && (emit || fin);
    assign o_result     = res;

    a_idle_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BOUNDARY || r_phase == PH_TOP_ESC || r_phase == PH_DISCARD)
        |-> (r_acc == '0 && r_left == '0))
        else $error("accumulator not clear outside an integer");

    a_multi_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MULTI || r_phase == PH_MULTI_ESC) |-> (r_left != '0))
        else $error("integer phase with no bytes left");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_result && o_result.is_end) |=> (r_count == '0 && !r_err))
        else $error("message state not cleared after end");

endmodule

/* rtl/evd_skid.sv */
module evd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  evd_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_out_ready,
    output evd_pkg::t_result o_result
);
    import evd_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_v && i_out_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push)
        else $error("result pushed into full buffer");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !r_skid_v && !i_push) |=> !r_out_v)
        else $error("output register still valid after drain");

endmodule

/* rtl/escaped_varint_decoder_top.sv */
// Escaped variable-length integer decoder.
// Input channel i_in carries one encoded byte per transfer (code_byte).
// Output channel o_out carries one result per transfer: a decoded value
// (integer minus one, mod 2^32), or an end-of-message result with is_end
// set and value_count holding the number of values decoded in the message.
// bad_escape reports whether an unknown escape code has been seen in the
// current message. Bytes that only advance the decode produce no result.
// Throughput is one byte per cycle while i_in.ready is high; the byte state
// machine and the shift into the 32-bit accumulator are combinational.
// Results reach o_out through the output register, via the skid if it is full.
// A two-entry output buffer (output register plus skid) keeps i_in ready
// while one result waits; i_in.ready drops only once both entries are held,
// and recovers the cycle after the receiver takes a result.
// max_values is written over the APB port at address 0; write it only
// while the block is idle. Synchronous reset returns the decoder to a value
// boundary with an empty message and max_values at 128.
module escaped_varint_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    evd_in_if.sink                          i_in,
    evd_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [evd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [evd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [evd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import evd_pkg::*;

    logic [COUNT_W-1:0] max_values;
    logic               accept;
    logic               in_ready;
    logic               has_result;
    t_result            core_res;
    t_result            out_res;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    evd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_values (max_values)
    );

    evd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_code_byte  (i_in.code_byte),
        .i_max_values (max_values),
        .o_has_result (has_result),
        .o_result     (core_res)
    );

    evd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (has_result),
        .i_result    (core_res),
        .o_ready     (in_ready),
        .o_valid     (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_result    (out_res)
    );

    assign o_out.value       = out_res.value;
    assign o_out.is_end      = out_res.is_end;
    assign o_out.value_count = out_res.value_count;
    assign o_out.bad_escape  = out_res.bad_escape;

endmodule
